### src/hpq_pkg.sv
// hpq_pkg: shared types and codes for the binary heap priority queue
// beat structs for the item and result channels, action and status codes
// no dependencies
`default_nettype none
package hpq_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 8;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  root_value;
    logic                root_valid;
    logic [COUNT_W-1:0]  entry_count;
  } out_beat_t;

endpackage
`default_nettype wire

### src/hpq_ram.sv
// hpq_ram: generic synchronous ram, one write port and two registered read ports
// no dependencies
`default_nettype none
module hpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### src/hpq_ctrl.sv
// hpq_ctrl: heap sequencer, sift up and sift down one level per cycle over the heap ram
// holds fill count, root copy and order register; uses hpq_pkg
`default_nettype none
module hpq_ctrl #(
  parameter int CAPACITY   = hpq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = hpq_pkg::VALUE_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int VW = VALUE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hpq_pkg::in_beat_t    in_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_bit,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output hpq_pkg::out_beat_t        res_data,
  output logic                      ram_we,
  output logic [AW-1:0]             ram_waddr,
  output logic [VW-1:0]             ram_wdata,
  output logic [AW-1:0]             ram_raddr_a,
  input  wire logic [VW-1:0]        ram_rdata_a,
  output logic [AW-1:0]             ram_raddr_b,
  input  wire logic [VW-1:0]        ram_rdata_b
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = AW + 2;
  localparam int XW = (VW > hpq_pkg::VALUE_W) ? VW : hpq_pkg::VALUE_W;
  localparam int YW = (CW > hpq_pkg::COUNT_W) ? CW : hpq_pkg::COUNT_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_UP_CMP  = 3'd1;
  localparam logic [2:0] ST_RM_LAST = 3'd2;
  localparam logic [2:0] ST_DN_CMP  = 3'd3;
  localparam logic [2:0] ST_WR_FIN  = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [AW-1:0]                  pos_r, pos_nxt;
  logic [VW-1:0]                  v_r, v_nxt;
  logic [VW-1:0]                  root_r, root_nxt;
  logic [hpq_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                           order_r;

  logic [XW-1:0]                  v_in_wide;
  logic [VW-1:0]                  v_in;
  logic [XW-1:0]                  root_wide;
  logic [YW-1:0]                  cnt_wide;
  logic [CW-1:0]                  cnt_m1;
  logic [KW-1:0]                  n_k;
  logic [KW-1:0]                  kid_l, kid_r, cidx, nl, nr;
  logic                           pick_r;
  logic [VW-1:0]                  cval;
  logic [AW-1:0]                  par, gpar;

  function automatic logic beats(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                 input logic ord);
    beats = ord ? (a > b) : (a < b);
  endfunction

  function automatic logic [KW-1:0] left_of(input logic [AW-1:0] p);
    left_of = {1'b0, p, 1'b1};
  endfunction

  assign v_in_wide = XW'(in_data.value);
  assign v_in      = v_in_wide[VW-1:0];
  assign root_wide = XW'(root_r);
  assign cnt_wide  = YW'(cnt_r);
  assign cnt_m1    = cnt_r - 1'b1;
  assign n_k       = KW'(cnt_r);

  // sift down child pick
  assign kid_l  = left_of(pos_r);
  assign kid_r  = kid_l + KW'(1);
  assign pick_r = (kid_r < n_k) && beats(ram_rdata_b, ram_rdata_a, order_r);
  assign cval   = pick_r ? ram_rdata_b : ram_rdata_a;
  assign cidx   = pick_r ? kid_r : kid_l;
  assign nl     = left_of(cidx[AW-1:0]);
  assign nr     = nl + KW'(1);

  // sift up parents
  assign par  = AW'((pos_r - 1'b1) >> 1);
  assign gpar = AW'((par - 1'b1) >> 1);

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  always_comb begin
    res_data             = '0;
    res_data.status      = status_r;
    res_data.root_valid  = (cnt_r != '0);
    res_data.root_value  = (cnt_r != '0) ? root_wide[hpq_pkg::VALUE_W-1:0] : '0;
    res_data.entry_count = cnt_wide[hpq_pkg::COUNT_W-1:0];
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    v_nxt       = v_r;
    status_nxt  = status_r;
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wdata   = v_r;
    ram_raddr_a = '0;
    ram_raddr_b = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = hpq_pkg::STAT_DONE;
          state_nxt  = ST_DONE;
          case (in_data.action)
            hpq_pkg::ACT_INSERT: begin
              if (cnt_r == CW'(CAPACITY)) begin
                status_nxt = hpq_pkg::STAT_FULL;
              end else begin
                cnt_nxt     = cnt_r + 1'b1;
                v_nxt       = v_in;
                pos_nxt     = cnt_r[AW-1:0];
                ram_raddr_a = AW'(cnt_m1 >> 1);
                state_nxt   = (cnt_r == '0) ? ST_WR_FIN : ST_UP_CMP;
              end
            end
            hpq_pkg::ACT_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = hpq_pkg::STAT_EMPTY;
              end else begin
                cnt_nxt     = cnt_m1;
                pos_nxt     = '0;
                ram_raddr_a = cnt_m1[AW-1:0];
                state_nxt   = ST_RM_LAST;
              end
            end
            hpq_pkg::ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (beats(ram_rdata_a, v_r, order_r)) begin
          state_nxt = ST_DONE;
        end else begin
          ram_wdata   = ram_rdata_a;
          pos_nxt     = par;
          ram_raddr_a = gpar;
          if (par == '0) begin
            state_nxt = ST_WR_FIN;
          end
        end
      end
      ST_RM_LAST: begin
        v_nxt       = ram_rdata_a;
        ram_raddr_a = AW'(1);
        ram_raddr_b = (cnt_r > CW'(2)) ? AW'(2) : AW'(1);
        if (cnt_r > CW'(1)) begin
          state_nxt = ST_DN_CMP;
        end else begin
          ram_we    = (cnt_r != '0);
          ram_waddr = '0;
          ram_wdata = ram_rdata_a;
          state_nxt = ST_DONE;
        end
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (beats(cval, v_r, order_r)) begin
          ram_wdata   = cval;
          pos_nxt     = cidx[AW-1:0];
          ram_raddr_a = nl[AW-1:0];
          ram_raddr_b = (nr < n_k) ? nr[AW-1:0] : nl[AW-1:0];
          state_nxt   = (nl < n_k) ? ST_DN_CMP : ST_WR_FIN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_WR_FIN: begin
        ram_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // root copy follows every write to entry zero
  assign root_nxt = (ram_we && ram_waddr == '0) ? ram_wdata : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      order_r  <= 1'b0;
      status_r <= hpq_pkg::STAT_DONE;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
      if (cfg_we) begin
        order_r <= cfg_bit;
      end
    end
    pos_r  <= pos_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
  end

endmodule
`default_nettype wire

### src/binary_heap_priority_queue.sv
// binary_heap_priority_queue: top level, heap sequencer, heap ram and result register
// depends on hpq_pkg, hpq_ctrl, hpq_ram
//
//   channel  handshake              payload
//   in_      in_valid / in_ready    hpq_pkg::in_beat_t  (action, value)
//   out_     out_valid / out_ready  hpq_pkg::out_beat_t (status, root, valid, count)
//   cfg_     cfg_valid / cfg_ready  heap_order, one bit, always ready
//
// insert and remove sift one heap level per cycle through the ram's two read
// ports and one write port, one item in flight at a time.
// reset is synchronous and empties the heap; ram contents are not cleared.
// a result waiting on out_ready holds in the output register while the next beat runs.
`default_nettype none
module binary_heap_priority_queue #(
  parameter int CAPACITY   = hpq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = hpq_pkg::VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hpq_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hpq_pkg::out_beat_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);

  localparam int AW = $clog2(CAPACITY);

  logic                 res_valid, res_ready;
  hpq_pkg::out_beat_t   res_data;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;
  logic                 out_valid_r;
  hpq_pkg::out_beat_t   out_data_r;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;

  hpq_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_bit     (cfg_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_rdata_a (ram_rdata_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_b (ram_rdata_b)
  );

  hpq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // output register for the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### src/hpq_checker.sv
// hpq_checker: port-level checks on the result channel of the heap queue
// depends on hpq_pkg; bound to binary_heap_priority_queue at the end of this file
`default_nettype none
module hpq_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire hpq_pkg::out_beat_t out_data
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.root_valid == (out_data.entry_count != '0)) &&
                  (out_data.root_valid || out_data.root_value == '0))
    else $error("root fields disagree with count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == hpq_pkg::STAT_EMPTY |->
      out_data.entry_count == '0 && !out_data.root_valid)
    else $error("empty status with entries held");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == hpq_pkg::STAT_FULL |-> out_data.root_valid)
    else $error("full status on empty heap");

endmodule

bind binary_heap_priority_queue hpq_checker u_hpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
